@@ rtl/core/i2c_master_bit_sequencer_defines.svh @@
// assertion macros used by the checker file
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// same-cycle implication, switched off while in reset
`define I2CMBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, switched off while in reset
`define I2CMBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/i2cmbs_pkg.sv @@
package i2cmbs_pkg;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;

  localparam int unsigned PHASE_W = 5;

  // result of one bus phase
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
    logic [1:0] sub_next;
    logic       ack_load;
    logic       ack_val;
    logic       last;
  } phase_res_t;

  function automatic logic [PHASE_W-1:0] op_len(input logic [2:0] op);
    logic [PHASE_W-1:0] len;
    unique case (op)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/i2c_master_bit_sequencer.sv @@
// channel  | dir | tdata fields, lowest bit first
// s_t*     | in  | mode[2:0] tx_byte[10:3] ack_out[11] sda_in[12], zero pad to 16
// m_t*     | out | scl[0] sda_out[1] busy_res[2] done_res[3] rx_byte[11:4] ack_in[12]
//
// every input item is one bus phase and yields one result item, one item per cycle while the output is not stalled
// the result sits in an output register from the cycle after the item is taken
// rst clears the line levels to released, the sequencer to idle and the output valid
// s_tready drops only while a result waits and m_tready is low
module i2c_master_bit_sequencer import i2cmbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // mode, tx_byte, ack_out, sda_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // scl, sda_out, busy_res, done_res, rx_byte, ack_in
);

  logic [2:0]         in_mode;
  logic [7:0]         in_tx_byte;
  logic               in_ack_out;
  logic               in_sda_in;
  logic               accept;

  logic               scl_level;
  logic               sda_level;
  logic [2:0]         cur_op;
  logic [PHASE_W-1:0] phase;
  logic [1:0]         sub;
  logic [7:0]         shift;
  logic [7:0]         rx_byte;
  logic               ack_latched;
  logic               ack_to_send;

  logic               scl_level_next;
  logic               sda_level_next;
  logic [2:0]         cur_op_next;
  logic [PHASE_W-1:0] phase_next;
  logic [1:0]         sub_next;
  logic [7:0]         shift_next;
  logic [7:0]         rx_byte_next;
  logic               ack_latched_next;
  logic               ack_to_send_next;
  logic               busy_next;
  logic               done_next;

  logic               cmd_start;
  logic [2:0]         eff_op;
  logic [PHASE_W-1:0] eff_phase;
  logic [1:0]         eff_sub;
  logic [7:0]         eff_shift;
  logic               eff_ack;
  phase_res_t         pres;

  logic [15:0]        out_data;

  assign in_mode    = s_tdata[2:0];
  assign in_tx_byte = s_tdata[10:3];
  assign in_ack_out = s_tdata[11];
  assign in_sda_in  = s_tdata[12];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // a command is taken only when idle
  assign cmd_start = (cur_op == OP_IDLE) && (in_mode >= OP_START) && (in_mode <= OP_RACK);
  assign eff_op    = cmd_start ? in_mode : cur_op;
  assign eff_phase = cmd_start ? '0 : phase;
  assign eff_sub   = cmd_start ? 2'd0 : sub;
  assign eff_shift = cmd_start ? ((in_mode == OP_WRITE) ? in_tx_byte : 8'd0) : shift;
  assign eff_ack   = cmd_start ? in_ack_out : ack_to_send;

  i2cmbs_phase u_phase (
    .op        (eff_op),
    .phase     (eff_phase),
    .sub       (eff_sub),
    .shift     (eff_shift),
    .ack_send  (eff_ack),
    .sda_in    (in_sda_in),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .res       (pres)
  );

  always_comb begin
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    cur_op_next      = cur_op;
    phase_next       = phase;
    sub_next         = sub;
    shift_next       = shift;
    rx_byte_next     = rx_byte;
    ack_latched_next = ack_latched;
    ack_to_send_next = eff_ack;
    busy_next        = 1'b0;
    done_next        = 1'b0;
    if (eff_op != OP_IDLE) begin
      busy_next      = 1'b1;
      scl_level_next = pres.scl;
      sda_level_next = pres.sda;
      shift_next     = pres.shift;
      if (pres.ack_load) ack_latched_next = pres.ack_val;
      if (pres.last) begin
        done_next   = 1'b1;
        cur_op_next = OP_IDLE;
        phase_next  = '0;
        sub_next    = 2'd0;
        if (eff_op == OP_READ) rx_byte_next = pres.shift;
      end else begin
        cur_op_next = eff_op;
        phase_next  = eff_phase + 5'd1;
        sub_next    = pres.sub_next;
      end
    end
  end

  assign out_data = {3'b000, ack_latched_next, rx_byte_next, done_next, busy_next,
                     sda_level_next, scl_level_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      cur_op      <= OP_IDLE;
      phase       <= '0;
      sub         <= 2'd0;
      shift       <= 8'd0;
      rx_byte     <= 8'd0;
      ack_latched <= 1'b0;
      ack_to_send <= 1'b0;
    end else if (accept) begin
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      cur_op      <= cur_op_next;
      phase       <= phase_next;
      sub         <= sub_next;
      shift       <= shift_next;
      rx_byte     <= rx_byte_next;
      ack_latched <= ack_latched_next;
      ack_to_send <= ack_to_send_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= out_data;
    end
  end

endmodule

@@ rtl/core/i2cmbs_phase.sv @@
module i2cmbs_phase import i2cmbs_pkg::*; (
  input  logic [2:0]         op,
  input  logic [PHASE_W-1:0] phase,
  input  logic [1:0]         sub,
  input  logic [7:0]         shift,
  input  logic               ack_send,
  input  logic               sda_in,
  input  logic               scl_level,
  input  logic               sda_level,
  output phase_res_t         res
);

  logic [PHASE_W:0] phase_inc;

  assign phase_inc = {1'b0, phase} + {{PHASE_W{1'b0}}, 1'b1};

  always_comb begin
    res          = '0;
    res.scl      = scl_level;
    res.sda      = sda_level;
    res.shift    = shift;
    res.sub_next = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
    res.ack_val  = sda_in;
    res.last     = phase_inc >= {1'b0, op_len(op)};
    unique case (op)
      OP_START: begin
        if (phase == 5'd0) res.sda = 1'b1;
        else if (phase == 5'd1) res.scl = 1'b1;
        else if (phase == 5'd2) res.sda = 1'b0;
        else res.scl = 1'b0;
      end
      OP_STOP: begin
        if (phase == 5'd0) res.sda = 1'b0;
        else if (phase == 5'd1) res.scl = 1'b1;
        else res.sda = 1'b1;
      end
      OP_WRITE: begin
        // any set msb releases sda
        if (sub == 2'd0) res.sda = shift[7];
        else if (sub == 2'd1) res.scl = 1'b1;
        else begin
          res.scl   = 1'b0;
          res.shift = {shift[6:0], 1'b0};
        end
      end
      OP_READ: begin
        if (phase == 5'd0) begin
          res.sda      = 1'b1;
          res.sub_next = 2'd0;
        end else if (sub == 2'd0) res.scl = 1'b1;
        else if (sub == 2'd1) res.shift = {shift[6:0], sda_in};
        else res.scl = 1'b0;
      end
      OP_SACK: begin
        if (phase == 5'd0) res.sda = ack_send;
        else if (phase == 5'd1) res.scl = 1'b1;
        else res.scl = 1'b0;
      end
      OP_RACK: begin
        if (phase == 5'd0) res.sda = 1'b1;
        else if (phase == 5'd1) res.scl = 1'b1;
        else if (phase == 5'd2) res.ack_load = 1'b1;
        else res.scl = 1'b0;
      end
      default: begin
        res.last = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/i2cmbs_checker.sv @@
`include "i2c_master_bit_sequencer_defines.svh"

module i2cmbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic in_seen;

  assign in_seen = s_tvalid || (s_tdata != 16'd0);

  `I2CMBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")
  `I2CMBS_ASSERT_NOW(a_done_busy, m_tvalid, !m_tdata[3] || m_tdata[2], "done without busy")
  `I2CMBS_ASSERT_NOW(a_ready_skid, !s_tready || !in_seen, !s_tready ? (m_tvalid && !m_tready) : 1'b1, "input stalled without a waiting item")
  `I2CMBS_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "output valid straight after reset")

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_i2cmbs_checker (.*);

@@ tb/sv/i2c_master_bit_sequencer_tb.sv @@
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_tb;
  import i2cmbs_pkg::*;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;

  // bit pattern fed to sda_in during a read
  localparam int RD_ONES = 0;
  localparam int RD_ZEROS = 1;
  localparam int RD_MIXED = 2;

  // result item, highest field first, so it lines up with m_tdata[12:0]
  typedef struct packed {
    logic       ack_in;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } phase_out_t;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] tx;
    logic       ack;
    logic       sda_in;
    logic       chk;
    phase_out_t lines;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // mode, tx_byte, ack_out, sda_in
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // scl, sda_out, busy_res, done_res, rx_byte, ack_in

  // sequencer copy kept by the bench
  logic       ln_scl, ln_sda;
  logic [2:0] cur_op;
  logic [4:0] phase;
  logic [7:0] shreg, rx_hold;
  logic       ack_hold, ack_drive;

  phase_out_t pending_lines[$];
  stim_row_t  directed_rows[DIRECTED_ROWS];
  logic       pin_chk;
  phase_out_t pin_lines;
  int         mismatches = 0;
  int         items_sent = 0;
  int         phases_seen = 0;
  int         cmd_count[8];
  int         idle_cycles = 0;
  int         hold_seen = 0;
  logic       calm;

  assign calm = items_sent >= 500 && items_sent < 800;

  i2c_master_bit_sequencer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned phases_of(input logic [2:0] op);
    case (op)
      OP_START: return 4;
      OP_STOP:  return 3;
      OP_WRITE: return 24;
      OP_READ:  return 25;
      OP_SACK:  return 3;
      OP_RACK:  return 4;
      default:  return 0;
    endcase
  endfunction

  // one bus phase: returns the line state and status seen after it
  function automatic phase_out_t advance_bus(input logic [2:0] mode, input logic [7:0] tx,
                                             input logic ack, input logic sda_in);
    phase_out_t r;
    int unsigned p;
    logic busy_now, done_now;
    busy_now = 1'b0;
    done_now = 1'b0;
    if (cur_op == OP_IDLE && mode >= OP_START && mode <= OP_RACK) begin
      cur_op = mode;
      phase = '0;
      shreg = (mode == OP_WRITE) ? tx : 8'h00;
      ack_drive = ack;
      cmd_count[mode]++;
    end
    if (cur_op != OP_IDLE) begin
      p = phase;
      case (cur_op)
        OP_START: begin
          if (p == 0) ln_sda = 1'b1;
          else if (p == 1) ln_scl = 1'b1;
          else if (p == 2) ln_sda = 1'b0;
          else ln_scl = 1'b0;
        end
        OP_STOP: begin
          if (p == 0) ln_sda = 1'b0;
          else if (p == 1) ln_scl = 1'b1;
          else ln_sda = 1'b1;
        end
        OP_WRITE: begin
          if (p % 3 == 0) ln_sda = shreg[7];
          else if (p % 3 == 1) ln_scl = 1'b1;
          else begin
            ln_scl = 1'b0;
            shreg = {shreg[6:0], 1'b0};
          end
        end
        OP_READ: begin
          // first phase releases sda, then scl high, sample, scl low per bit
          if (p == 0) ln_sda = 1'b1;
          else if ((p - 1) % 3 == 0) ln_scl = 1'b1;
          else if ((p - 1) % 3 == 1) shreg = {shreg[6:0], sda_in};
          else ln_scl = 1'b0;
        end
        OP_SACK: begin
          if (p == 0) ln_sda = ack_drive;
          else if (p == 1) ln_scl = 1'b1;
          else ln_scl = 1'b0;
        end
        OP_RACK: begin
          if (p == 0) ln_sda = 1'b1;
          else if (p == 1) ln_scl = 1'b1;
          else if (p == 2) ack_hold = sda_in;
          else ln_scl = 1'b0;
        end
        default: ;
      endcase
      busy_now = 1'b1;
      phase = phase + 5'd1;
      if (phase >= phases_of(cur_op)) begin
        done_now = 1'b1;
        if (cur_op == OP_READ) rx_hold = shreg;
        cur_op = OP_IDLE;
        phase = '0;
      end
    end
    r.scl = ln_scl;
    r.sda = ln_sda;
    r.busy = busy_now;
    r.done = done_now;
    r.rx_byte = rx_hold;
    r.ack_in = ack_hold;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    phase_out_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = phase_out_t'(m_tdata[12:0]);
        if (pending_lines.size() == 0) begin
          $display("%0t: result %0h with no item outstanding", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_lines.pop_front();
          check_field("scl", want.scl, got.scl);
          check_field("sda_out", want.sda, got.sda);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_in", want.ack_in, got.ack_in);
        end
        phases_seen++;
      end
      if (s_tvalid && s_tready) begin
        want = advance_bus(s_tdata[2:0], s_tdata[10:3], s_tdata[11], s_tdata[12]);
        pending_lines.push_back(pin_chk ? pin_lines : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("i2c_master_bit_sequencer_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls plus one long hold-off to back up the input
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_seen == 0 && items_sent >= 1200) begin
        m_tready <= 1'b0;
        while (hold_seen < HOLD_OFF_CYCLES - 1) begin
          @(negedge clk);
          hold_seen++;
        end
        hold_seen++;
      end else begin
        m_tready <= calm || $urandom_range(99) >= 7;
      end
    end
  end

  task automatic send_phase(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                            input logic sda_in, input logic chk, input phase_out_t lines);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, sda_in, ack, tx, mode};
    pin_chk <= chk;
    pin_lines <= lines;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] tx;
    logic       sda_in;
    int         rd_style;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    pin_chk = 1'b0;
    pin_lines = '0;
    rd_style = RD_MIXED;
    for (int i = 0; i < 8; i++) cmd_count[i] = 0;
    ln_scl = 1'b1;
    ln_sda = 1'b1;
    cur_op = OP_IDLE;
    phase = '0;
    shreg = '0;
    rx_hold = '0;
    ack_hold = 1'b0;
    ack_drive = 1'b0;

    // mode, tx, ack, sda_in, typed check, {ack_in, rx_byte, done, busy, sda, scl}
    directed_rows[0]  = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}};
    directed_rows[1]  = '{MODE_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1}};
    directed_rows[2]  = '{OP_START,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}};
    // commands while busy are dropped
    directed_rows[3]  = '{OP_WRITE,   8'hFF, 1'b1, 1'b1, 1'b0, '0};
    directed_rows[4]  = '{OP_READ,    8'h00, 1'b0, 1'b1, 1'b0, '0};
    directed_rows[5]  = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}};
    directed_rows[6]  = '{OP_STOP,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[7]  = '{OP_START,   8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[8]  = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1}};
    directed_rows[9]  = '{OP_SACK,    8'h00, 1'b1, 1'b0, 1'b0, '0};
    directed_rows[10] = '{OP_SACK,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[11] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[12] = '{OP_RACK,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[13] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[14] = '{OP_IDLE,    8'h00, 1'b0, 1'b1, 1'b0, '0};
    directed_rows[15] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[16] = '{OP_RACK,    8'h00, 1'b0, 1'b1, 1'b0, '0};
    directed_rows[17] = '{OP_IDLE,    8'h00, 1'b0, 1'b1, 1'b0, '0};
    directed_rows[18] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[19] = '{OP_IDLE,    8'h00, 1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0}};
    directed_rows[20] = '{MODE_SPARE, 8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0}};
    directed_rows[21] = '{OP_WRITE,   8'h80, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[22] = '{OP_WRITE,   8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[23] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b0, '0};
    directed_rows[24] = '{OP_IDLE,    8'h00, 1'b0, 1'b0, 1'b0, '0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_phase(directed_rows[i].mode, directed_rows[i].tx, directed_rows[i].ack,
                 directed_rows[i].sda_in, directed_rows[i].chk, directed_rows[i].lines);

    // mostly whole commands with random content, some idle noise in between
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(7))
        0: tx = 8'h00;
        1: tx = 8'hFF;
        default: tx = 8'($urandom_range(255));
      endcase
      if (cur_op == OP_IDLE) begin
        if ($urandom_range(99) < 10) mode = $urandom_range(1) ? OP_IDLE : MODE_SPARE;
        else mode = 3'($urandom_range(OP_START, OP_RACK));
        if (mode == OP_READ) rd_style = $urandom_range(3);
        send_phase(mode, tx, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end else begin
        mode = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : OP_IDLE;
        if (cur_op == OP_READ && rd_style == RD_ONES) sda_in = 1'b1;
        else if (cur_op == OP_READ && rd_style == RD_ZEROS) sda_in = 1'b0;
        else sda_in = 1'($urandom_range(1));
        send_phase(mode, tx, 1'($urandom_range(1)), sda_in, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bus phases checked; commands: %0d start, %0d stop, %0d write, %0d read,",
             phases_seen, cmd_count[OP_START], cmd_count[OP_STOP], cmd_count[OP_WRITE],
             cmd_count[OP_READ]);
    $display("%0d send ack, %0d receive ack; output held off %0d cycles in one stretch",
             cmd_count[OP_SACK], cmd_count[OP_RACK], hold_seen);
    if (mismatches == 0) begin
      $display("i2c_master_bit_sequencer_tb: done, clean");
    end else begin
      $display("i2c_master_bit_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/i2cmbs_pkg.sv
rtl/core/i2cmbs_phase.sv
rtl/core/i2c_master_bit_sequencer.sv
rtl/core/i2cmbs_checker.sv
tb/sv/i2c_master_bit_sequencer_tb.sv
